// ===== rtl/hfs_pkg.sv =====
// Shared constants for the height-field sampler: field widths, register
// indexes and operation codes. No dependencies.
package hfs_pkg;

  localparam int POS_BITS    = 18;
  localparam int ENTRY_BITS  = 16;
  localparam int OUT_H_BITS  = 16;
  localparam int NORM_BITS   = 16;
  localparam int NORM_Y_BITS = 15;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_COLS  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROWS  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_SCALE = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [15:0] NORM_CAP = 16'd16384;

endpackage

// ===== rtl/hfs_ram.sv =====
// Generic single-port RAM with registered read data.
// Depends on nothing.
module hfs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  parameter int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] addr,
  input  logic [WIDTH-1:0]     wdata,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/heightfield_bilinear_sampler.sv =====
// Top level of the height-field sampler: sequencer, shared multiplier,
// square-root and divider steps. Depends on hfs_pkg and hfs_ram.
//
// Usage:
//   s_axis carries requests. s_axis_tuser is op: 0 writes one grid entry,
//   1 queries height and normal at a fractional position.
//   m_axis carries one result per query; writes give no result.
//   cfg_* writes a register (0 cols_in_use, 1 rows_in_use, 2 height_scale);
//   write it only while the block is idle. cfg_ready is always high.
// Sequence:
//   A write request is taken and the block is ready again at once.
//   A query holds s_axis_tready low while it runs: five samples, each with
//   a split, an address multiply, read steps on the single RAM port, and
//   blend and scale on the one shared multiplier; then the squares, the
//   bit-pair square root and the restoring divider for each of the three
//   normal components, then loading of the output register.
// Reset: clear the sequencer and the output valid, restore register defaults
//   (256, 256, 4096). The grid store is not cleared.
// Stall: hold a finished result in the output register; write requests keep
//   flowing, and a second query holds in its last step until the receiver
//   takes the first result.
module heightfield_bilinear_sampler #(
  parameter int GRID_COLS   = 256,
  parameter int GRID_ROWS   = 256,
  parameter int HEIGHT_BITS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata fields from bit 0: entry_index[15:0], entry_height[31:16],
  // x_pos[49:32], y_pos[67:50], zero pad[71:68]
  input  logic [71:0] s_axis_tdata,
  // tuser fields from bit 0: op[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata fields from bit 0: height_out[15:0], normal_x[31:16],
  // normal_y[46:32], normal_z[62:47], zero pad[63]
  output logic [63:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [hfs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [hfs_pkg::CFG_DATA_BITS-1:0] cfg_data
);
  import hfs_pkg::*;

  localparam int HB    = HEIGHT_BITS;
  localparam int F     = FRAC_BITS;
  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(GRID_COLS + 1);
  localparam int RW    = $clog2(GRID_ROWS + 1);
  localparam int PW    = POS_BITS + 1;
  localparam int L1W   = HB + 2;
  localparam int MAW   = (HB + 4 > 17) ? HB + 4 : 17;
  localparam int MBW   = (F + 1 > 17) ? F + 1 : 17;
  localparam int PRW   = MAW + MBW;
  localparam int SQW   = 34;
  localparam int RVW   = 64;
  localparam int DVW   = 47;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_SPLIT = 5'd1;
  localparam logic [4:0] ST_BASE  = 5'd2;
  localparam logic [4:0] ST_ADDR  = 5'd3;
  localparam logic [4:0] ST_READ  = 5'd4;
  localparam logic [4:0] ST_BL0   = 5'd5;
  localparam logic [4:0] ST_BL1   = 5'd6;
  localparam logic [4:0] ST_BL2   = 5'd7;
  localparam logic [4:0] ST_BL3   = 5'd8;
  localparam logic [4:0] ST_BL4   = 5'd9;
  localparam logic [4:0] ST_SQ0   = 5'd10;
  localparam logic [4:0] ST_SQ1   = 5'd11;
  localparam logic [4:0] ST_SQ2   = 5'd12;
  localparam logic [4:0] ST_ROOT  = 5'd13;
  localparam logic [4:0] ST_DLOAD = 5'd14;
  localparam logic [4:0] ST_DIV   = 5'd15;
  localparam logic [4:0] ST_DONE  = 5'd16;

  // configuration
  logic [8:0]  cols_in_use;
  logic [8:0]  rows_in_use;
  logic [15:0] height_scale;

  logic [4:0] state;
  logic [2:0] k;          // which of the five samples
  logic [2:0] rd_idx;
  logic [4:0] cnt;        // square-root step
  logic [3:0] dcnt;       // divider step
  logic [1:0] dcomp;      // which normal component

  logic signed [POS_BITS-1:0] x_r, y_r;
  logic [CW-1:0] cx;
  logic [RW-1:0] cy;
  logic signed [F:0] fx, fy;
  logic [AW-1:0] base;
  logic [HB-1:0] s [4];
  logic signed [L1W-1:0] r0;
  logic [15:0] hk [5];
  logic signed [MAW-1:0] ma;
  logic signed [MBW-1:0] mb;
  logic signed [PRW-1:0] prod;
  logic [SQW-1:0] sq;
  logic [RVW-1:0] rv, res;
  logic [DVW-1:0] rem;
  logic [15:0] q;
  logic [15:0] nx, nz;
  logic [14:0] ny;
  logic [15:0] h_out;
  logic        m_valid;
  logic [15:0] o_h, o_nx, o_nz;
  logic [14:0] o_ny;

  // RAM port
  logic          ram_we;
  logic [AW-1:0] ram_addr;
  logic [HB-1:0] ram_rdata;

  logic in_acc;
  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready = 1'b1;

  // clamped grid sizes
  logic [CW-1:0] cols_lim;
  logic [RW-1:0] rows_lim;
  always_comb begin
    if (cols_in_use < 9'd2) cols_lim = CW'(2);
    else if (32'(cols_in_use) > 32'(GRID_COLS)) cols_lim = CW'(GRID_COLS);
    else cols_lim = CW'(cols_in_use);
    if (rows_in_use < 9'd2) rows_lim = RW'(2);
    else if (32'(rows_in_use) > 32'(GRID_ROWS)) rows_lim = RW'(GRID_ROWS);
    else rows_lim = RW'(rows_in_use);
  end

  // position split for the current sample
  logic signed [PW-1:0] px, py, ax, ay, ipx, ipy;
  logic [PW-1:0] magx, magy;
  logic signed [F:0] frx, fry;
  logic [CW-1:0] cx_c;
  logic [RW-1:0] cy_c;
  localparam logic signed [PW-1:0] ONE = PW'(1) << F;
  localparam logic [PW-1:0] FMASK = (PW'(1) << F) - PW'(1);

  always_comb begin
    px = PW'(x_r);
    py = PW'(y_r);
    case (k)
      3'd1: px = PW'(x_r) + ONE;
      3'd2: px = PW'(x_r) - ONE;
      3'd3: py = PW'(y_r) + ONE;
      3'd4: py = PW'(y_r) - ONE;
      default: ;
    endcase
    ax = px[PW-1] ? -px : px;
    ay = py[PW-1] ? -py : py;
    magx = ax;
    magy = ay;
    ipx = px[PW-1] ? -$signed(magx >> F) : $signed(magx >> F);
    ipy = py[PW-1] ? -$signed(magy >> F) : $signed(magy >> F);
    frx = px[PW-1] ? -$signed((F+1)'(magx & FMASK)) : $signed((F+1)'(magx & FMASK));
    fry = py[PW-1] ? -$signed((F+1)'(magy & FMASK)) : $signed((F+1)'(magy & FMASK));
    if (ipx[PW-1]) cx_c = '0;
    else if (32'(ipx) > 32'(cols_lim - CW'(2))) cx_c = cols_lim - CW'(2);
    else cx_c = CW'(ipx);
    if (ipy[PW-1]) cy_c = '0;
    else if (32'(ipy) > 32'(rows_lim - RW'(2))) cy_c = rows_lim - RW'(2);
    else cy_c = RW'(ipy);
  end

  // blend and normal helpers
  logic signed [HB:0] d_a, d_b;
  logic signed [PRW-1:0] prod_sh, hs;
  logic signed [L1W-1:0] r1c;
  logic signed [16:0] dxv, dzv;
  assign d_a = $signed({1'b0, s[1]}) - $signed({1'b0, s[0]});
  assign d_b = $signed({1'b0, s[3]}) - $signed({1'b0, s[2]});
  assign prod_sh = prod >>> F;
  assign hs = prod >>> HB;
  assign r1c = L1W'($signed({1'b0, s[2]}) + prod_sh);
  assign dxv = $signed({1'b0, hk[1]}) - $signed({1'b0, hk[2]});
  assign dzv = $signed({1'b0, hk[3]}) - $signed({1'b0, hk[4]});

  logic [15:0] h_sat;
  always_comb begin
    if (hs < 0) h_sat = 16'd0;
    else if (hs > $signed(PRW'(65535))) h_sat = 16'hFFFF;
    else h_sat = hs[15:0];
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      ST_BASE: begin
        ma = MAW'($signed({1'b0, cols_lim}));
        mb = MBW'($signed({1'b0, cy}));
      end
      ST_BL0: begin
        ma = MAW'(d_a);
        mb = MBW'(fx);
      end
      ST_BL1: begin
        ma = MAW'(d_b);
        mb = MBW'(fx);
      end
      ST_BL2: begin
        ma = MAW'(r1c) - MAW'(r0);
        mb = MBW'(fy);
      end
      ST_BL3: begin
        ma = MAW'(r0) + MAW'(prod_sh);
        mb = MBW'($signed({1'b0, height_scale}));
      end
      ST_SQ0: begin
        ma = MAW'(dxv);
        mb = MBW'(dxv);
      end
      ST_SQ1: begin
        ma = MAW'(dzv);
        mb = MBW'(dzv);
      end
      default: ;
    endcase
  end

  // square-root step
  logic [RVW-1:0] bitv, rt;
  assign bitv = RVW'(1) << {cnt, 1'b0};
  assign rt = res + bitv;

  // divider step
  logic [32:0] len;
  logic [DVW-1:0] dt;
  logic [15:0] q_next, qcap, mag;
  logic comp_neg;
  assign len = res[32:0];
  assign dt = DVW'(len) << dcnt;
  assign q_next = (rem >= dt) ? (q | (16'd1 << dcnt)) : q;
  assign qcap = (q_next > NORM_CAP) ? NORM_CAP : q_next;
  always_comb begin
    case (dcomp)
      2'd0: begin
        mag = dxv[16] ? 16'(-dxv) : dxv[15:0];
        comp_neg = dxv[16];
      end
      2'd2: begin
        mag = dzv[16] ? 16'(-dzv) : dzv[15:0];
        comp_neg = dzv[16];
      end
      default: begin
        mag = 16'd32;
        comp_neg = 1'b0;
      end
    endcase
  end

  // RAM address and write enable
  logic [31:0] widx;
  assign widx = 32'(s_axis_tdata[15:0]);
  always_comb begin
    ram_we = in_acc && (s_axis_tuser == OP_WRITE) && (widx < 32'(DEPTH));
    if (state == ST_IDLE) ram_addr = AW'(widx);
    else ram_addr = base + AW'(rd_idx[0]) + (rd_idx[1] ? AW'(cols_lim) : AW'(0));
  end

  hfs_ram #(
    .WIDTH(HB),
    .DEPTH(DEPTH),
    .ADDR_BITS(AW)
  ) u_store (
    .clk(clk),
    .we(ram_we),
    .addr(ram_addr),
    .wdata(HB'(s_axis_tdata[31:16])),
    .rdata(ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cols_in_use  <= 9'd256;
      rows_in_use  <= 9'd256;
      height_scale <= 16'd4096;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_COLS:  cols_in_use  <= cfg_data[8:0];
        REG_ROWS:  rows_in_use  <= cfg_data[8:0];
        REG_SCALE: height_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= ma * mb;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      m_valid <= 1'b0;
    end else begin
      // drop the taken result; the done step reloads it itself
      if (m_valid && m_axis_tready && (state != ST_DONE)) begin
        m_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_acc && (s_axis_tuser == OP_QUERY)) begin
            x_r   <= s_axis_tdata[49:32];
            y_r   <= s_axis_tdata[67:50];
            k     <= 3'd0;
            state <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          cx    <= cx_c;
          cy    <= cy_c;
          fx    <= frx;
          fy    <= fry;
          state <= ST_BASE;
        end
        ST_BASE: state <= ST_ADDR;
        ST_ADDR: begin
          base   <= AW'(prod) + AW'(cx);
          rd_idx <= 3'd0;
          state  <= ST_READ;
        end
        ST_READ: begin
          // catch the word addressed in the previous cycle
          if (rd_idx != 3'd0) begin
            s[2'(rd_idx - 3'd1)] <= ram_rdata;
          end
          rd_idx <= rd_idx + 3'd1;
          if (rd_idx == 3'd4) state <= ST_BL0;
        end
        ST_BL0: state <= ST_BL1;
        ST_BL1: begin
          r0    <= L1W'($signed({1'b0, s[0]}) + prod_sh);
          state <= ST_BL2;
        end
        ST_BL2: state <= ST_BL3;
        ST_BL3: state <= ST_BL4;
        ST_BL4: begin
          hk[k] <= h_sat;
          if (k == 3'd4) begin
            state <= ST_SQ0;
          end else begin
            k     <= k + 3'd1;
            state <= ST_SPLIT;
          end
        end
        ST_SQ0: state <= ST_SQ1;
        ST_SQ1: begin
          sq    <= SQW'(prod) + SQW'(1024);
          state <= ST_SQ2;
        end
        ST_SQ2: begin
          rv    <= RVW'({sq + SQW'(prod), 28'd0});
          res   <= '0;
          cnt   <= 5'd31;
          state <= ST_ROOT;
        end
        ST_ROOT: begin
          if (rv >= rt) begin
            rv  <= rv - rt;
            res <= (res >> 1) + bitv;
          end else begin
            res <= res >> 1;
          end
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            dcomp <= 2'd0;
            state <= ST_DLOAD;
          end
        end
        ST_DLOAD: begin
          rem   <= (DVW'(mag) << 28) + DVW'(len >> 1);
          q     <= '0;
          dcnt  <= 4'd15;
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (rem >= dt) rem <= rem - dt;
          q    <= q_next;
          dcnt <= dcnt - 4'd1;
          if (dcnt == 4'd0) begin
            case (dcomp)
              2'd0: nx <= comp_neg ? -qcap : qcap;
              2'd1: ny <= qcap[14:0];
              default: nz <= comp_neg ? -qcap : qcap;
            endcase
            if (dcomp == 2'd2) begin
              h_out <= hk[0];
              state <= ST_DONE;
            end else begin
              dcomp <= dcomp + 2'd1;
              state <= ST_DLOAD;
            end
          end
        end
        ST_DONE: begin
          // hold until the output register is free
          if (!m_valid || m_axis_tready) begin
            o_h     <= h_out;
            o_nx    <= nx;
            o_ny    <= ny;
            o_nz    <= nz;
            m_valid <= 1'b1;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = {1'b0, o_nz, o_ny, o_nx, o_h};

endmodule
